/* design/lsi_pkg.sv */
// Shared types and constants for the Q15 LMS system identifier.
package lsi_pkg;

    localparam int DATA_W    = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int FRAC_BITS = 15;
    localparam int SCALED_W  = 2 * DATA_W;
    localparam int UPD_W     = SCALED_W + DATA_W;
    localparam int CFG_IDX_W = 3;
    localparam int MAX_TAPS  = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF0 = 3'd1;

    localparam logic signed [DATA_W-1:0] STEP_RESET = 16'sd5;
    localparam logic signed [DATA_W-1:0] COEF_RESET = 16'sd8192;

    typedef logic signed [DATA_W-1:0]   t_sample;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [SCALED_W-1:0] t_scaled;

    // per-cell strobes from the sequencer
    typedef struct packed {
        logic shift;  // load new window sample from left neighbor
        logic mul;    // register coef and weight products
        logic upd;    // apply weight update
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_SCALE,
        S_UPD
    } t_state;

endpackage

/* design/lsi_tap_cell.sv */
// One tap cell: window sample, adapted weight, products and sum chain stage.
module lsi_tap_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lsi_pkg::t_cell_ctrl i_ctrl,
    input  lsi_pkg::t_sample    i_sample,      // from left neighbor or input word
    input  lsi_pkg::t_sample    i_coef,
    input  lsi_pkg::t_scaled    i_scaled_err,  // step * error
    input  lsi_pkg::t_sample    i_d_sum,
    input  lsi_pkg::t_sample    i_y_sum,
    output lsi_pkg::t_sample    o_sample,
    output lsi_pkg::t_sample    o_d_sum,
    output lsi_pkg::t_sample    o_y_sum
);

    lsi_pkg::t_sample r_win;
    lsi_pkg::t_sample r_weight;
    lsi_pkg::t_prod   r_prod_d;
    lsi_pkg::t_prod   r_prod_y;

    logic signed [lsi_pkg::UPD_W-1:0] upd_prod;
    lsi_pkg::t_sample                 n_weight;

    always_comb begin
        upd_prod = i_scaled_err * r_win;
        // asr15 then wrap16 keeps bits [30:15]
        n_weight = r_weight
                 + upd_prod[lsi_pkg::FRAC_BITS +: lsi_pkg::DATA_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= '0;
            r_weight <= '0;
        end else begin
            if (i_ctrl.shift) begin
                r_win <= i_sample;
            end
            if (i_ctrl.upd) begin
                r_weight <= n_weight;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_prod_d <= i_coef * r_win;
            r_prod_y <= r_weight * r_win;
        end
    end

    assign o_sample = r_win;
    assign o_d_sum  = i_d_sum + r_prod_d[lsi_pkg::FRAC_BITS +: lsi_pkg::DATA_W];
    assign o_y_sum  = i_y_sum + r_prod_y[lsi_pkg::FRAC_BITS +: lsi_pkg::DATA_W];

endmodule

/* design/lms_system_identifier_q15.sv */
// Top level of the Q15 LMS system identifier: sequencer, registers, tap cell row.
//
// Q15 LMS adaptive FIR that learns a fixed reference FIR. Each word on the
// slave stream is one signed 16-bit sample; the block returns one word on the
// master stream per sample: desired minus estimate, wrapped to 16 bits, where
// desired uses the programmed reference coefficients and estimate the adapted
// weights. The taps form a row of NUM_TAPS cells; each holds its window sample
// and weight and passes the sample and the partial sums to its right-hand
// neighbor. Sequence: a sample takes the products, then the sum chain and
// error, then step*error plus output load, then the weight update; the next
// sample is taken in the update cycle, so one sample at a time is in flight,
// set by the one error value that every cell's update needs. If the output
// word is still waiting, the sample holds in the scale step until it drains.
// Configuration: write enable, 3-bit index (0 step_size, 1..4 ref_coef_0..3),
// 16-bit data; indexes beyond the tap count are ignored. Write only while
// idle. Reset is synchronous, active low.
module lms_system_identifier_q15 #(
    parameter int NUM_TAPS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] sample_in
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] error_out
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    lsi_pkg::t_state     r_state;
    lsi_pkg::t_state     n_state;
    lsi_pkg::t_cell_ctrl cell_ctrl;

    lsi_pkg::t_sample r_step;
    lsi_pkg::t_sample r_coef [NUM_TAPS];
    lsi_pkg::t_sample r_err;
    lsi_pkg::t_scaled r_scaled;
    logic             r_out_valid;
    lsi_pkg::t_sample r_out_data;

    lsi_pkg::t_sample smp_chain [NUM_TAPS+1];
    lsi_pkg::t_sample d_chain   [NUM_TAPS+1];
    lsi_pkg::t_sample y_chain   [NUM_TAPS+1];

    logic s_accept;
    logic out_free;
    logic out_load;

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        cell_ctrl       = '0;
        out_load        = 1'b0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            lsi_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                cell_ctrl.shift = i_s_axis_tvalid;
                if (i_s_axis_tvalid) begin
                    n_state = lsi_pkg::S_MUL;
                end
            end
            lsi_pkg::S_MUL: begin
                cell_ctrl.mul = 1'b1;
                n_state       = lsi_pkg::S_SUM;
            end
            lsi_pkg::S_SUM: begin
                n_state = lsi_pkg::S_SCALE;
            end
            lsi_pkg::S_SCALE: begin
                // hold here until the output register is free
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = lsi_pkg::S_UPD;
                end
            end
            lsi_pkg::S_UPD: begin
                // weights update and next sample shifts in on the same edge
                o_s_axis_tready = 1'b1;
                cell_ctrl.upd   = 1'b1;
                cell_ctrl.shift = i_s_axis_tvalid;
                n_state         = i_s_axis_tvalid ? lsi_pkg::S_MUL : lsi_pkg::S_IDLE;
            end
            default: begin
                n_state = lsi_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= lsi_pkg::STEP_RESET;
        end else if (i_cfg_wr_en && i_cfg_index == lsi_pkg::REG_STEP) begin
            r_step <= i_cfg_wdata;
        end
    end

    for (genvar k = 0; k < NUM_TAPS; k++) begin : g_coef
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_coef[k] <= lsi_pkg::COEF_RESET;
            end else if (i_cfg_wr_en
                         && i_cfg_index == lsi_pkg::REG_COEF0 + lsi_pkg::CFG_IDX_W'(k)) begin
                r_coef[k] <= i_cfg_wdata;
            end
        end
    end

    // ---------------- tap cell row ----------------
    assign smp_chain[0] = i_s_axis_tdata;
    assign d_chain[0]   = '0;
    assign y_chain[0]   = '0;

    for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
        lsi_tap_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (cell_ctrl),
            .i_sample     (smp_chain[k]),
            .i_coef       (r_coef[k]),
            .i_scaled_err (r_scaled),
            .i_d_sum      (d_chain[k]),
            .i_y_sum      (y_chain[k]),
            .o_sample     (smp_chain[k+1]),
            .o_d_sum      (d_chain[k+1]),
            .o_y_sum      (y_chain[k+1])
        );
    end

    // ---------------- error and scaled error ----------------
    always_ff @(posedge i_clk) begin
        if (r_state == lsi_pkg::S_SUM) begin
            r_err <= d_chain[NUM_TAPS] - y_chain[NUM_TAPS];
        end
        if (r_state == lsi_pkg::S_SCALE) begin
            r_scaled <= r_step * r_err;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= r_err;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ---------------- assertions ----------------
    a_accept_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |-> (r_state == lsi_pkg::S_IDLE || r_state == lsi_pkg::S_UPD))
        else $error("sample accepted outside idle or update");

    a_out_from_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == lsi_pkg::S_SCALE)
        else $error("output word loaded outside scale step");

    a_upd_holds_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lsi_pkg::S_UPD) |-> (r_out_data == r_err))
        else $error("output word differs from error during update");

    a_scale_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lsi_pkg::S_UPD) |-> $past(r_state) == lsi_pkg::S_SCALE)
        else $error("weight update without scale step");

endmodule

/* tb/lms_system_identifier_q15_tb.sv */
// Self-checking testbench for the Q15 LMS system identifier with an error-word scoreboard.
`timescale 1ns / 100ps

// Tracks the filter state and predicts every error word in arrival order.
class error_scoreboard;
    int               taps;
    lsi_pkg::t_sample step;
    lsi_pkg::t_sample coef[lsi_pkg::MAX_TAPS];
    lsi_pkg::t_sample wt[lsi_pkg::MAX_TAPS];
    lsi_pkg::t_sample hist[lsi_pkg::MAX_TAPS-1];
    lsi_pkg::t_sample err_q[$];
    int               fails;

    function new(int n_taps);
        taps  = n_taps;
        step  = lsi_pkg::STEP_RESET;
        fails = 0;
        foreach (coef[n]) begin
            coef[n] = lsi_pkg::COEF_RESET;
            wt[n]   = '0;
        end
        foreach (hist[n]) hist[n] = '0;
    endfunction

    // Register write as seen at the write edge; out-of-range indexes drop.
    function void set_reg(logic [lsi_pkg::CFG_IDX_W-1:0] idx, lsi_pkg::t_sample val);
        if (idx == lsi_pkg::REG_STEP) begin
            step = val;
        end else if (idx >= lsi_pkg::REG_COEF0 && idx < lsi_pkg::REG_COEF0 + taps) begin
            coef[idx - lsi_pkg::REG_COEF0] = val;
        end
    endfunction

    // Accepted sample: form the window, compute the error, adapt the weights.
    function void note_sample(lsi_pkg::t_sample x);
        lsi_pkg::t_sample tap[lsi_pkg::MAX_TAPS];
        lsi_pkg::t_sample d;
        lsi_pkg::t_sample y;
        lsi_pkg::t_sample e;
        longint signed    p;
        tap[0] = x;
        for (int n = 1; n < lsi_pkg::MAX_TAPS; n++) begin
            tap[n] = (n < taps) ? hist[n-1] : lsi_pkg::t_sample'(0);
        end
        d = '0;
        y = '0;
        for (int n = 0; n < taps; n++) begin
            // >>> on a signed longint floors toward minus infinity
            d = lsi_pkg::t_sample'(longint'(d)
                + ((longint'(coef[n]) * longint'(tap[n])) >>> lsi_pkg::FRAC_BITS));
            y = lsi_pkg::t_sample'(longint'(y)
                + ((longint'(wt[n]) * longint'(tap[n])) >>> lsi_pkg::FRAC_BITS));
        end
        e = lsi_pkg::t_sample'(longint'(d) - longint'(y));
        for (int n = 0; n < taps; n++) begin
            p = longint'(step) * longint'(e) * longint'(tap[n]);
            wt[n] = lsi_pkg::t_sample'(longint'(wt[n]) + (p >>> lsi_pkg::FRAC_BITS));
        end
        for (int n = taps - 2; n >= 1; n--) hist[n] = hist[n-1];
        if (taps > 1) hist[0] = x;
        err_q.push_back(e);
    endfunction

    function void check_error(logic [lsi_pkg::DATA_W-1:0] got);
        lsi_pkg::t_sample exp_err;
        if (err_q.size() == 0) begin
            $display("%0t: error word with none expected, expected none actual %0d",
                     $time, $signed(got));
            fails++;
        end else begin
            exp_err = err_q.pop_front();
            if (got !== exp_err) begin
                $display("%0t: error_out mismatch, expected %0d actual %0d",
                         $time, exp_err, $signed(got));
                fails++;
            end
        end
    endfunction

    function int pending();
        return err_q.size();
    endfunction
endclass

module lms_system_identifier_q15_tb;

    localparam int N_TAPS         = 4;
    localparam int RESET_CYCLES   = 11;
    // covers the weight update that follows the output load, with margin
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RAND_PHASES    = 9;
    localparam int PHASE_WORDS    = 55;
    // first index past the tap registers; writes from here up are dropped
    localparam logic [lsi_pkg::CFG_IDX_W-1:0] REG_SPARE0 =
        lsi_pkg::CFG_IDX_W'(lsi_pkg::REG_COEF0 + lsi_pkg::MAX_TAPS);

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_valid  = 1'b0;
    logic                          s_ready;
    lsi_pkg::t_sample              s_data   = '0;
    logic                          m_valid;
    logic                          m_ready  = 1'b0;
    logic [lsi_pkg::DATA_W-1:0]    m_data;
    logic                          cfg_en   = 1'b0;
    logic [lsi_pkg::CFG_IDX_W-1:0] cfg_idx  = '0;
    lsi_pkg::t_sample              cfg_data = '0;

    error_scoreboard  sb;
    lsi_pkg::t_sample batch[$];
    int               stall_cnt = 0;

    // Idle-run state per side: a run of words either idles at random or not at all.
    int s_left = 0;
    bit s_quiet = 1'b0;
    int m_left = 0;
    bit m_quiet = 1'b0;

    lms_system_identifier_q15 #(
        .NUM_TAPS(N_TAPS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),     // [15:0] sample_in
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),     // [15:0] error_out
        .i_cfg_wr_en     (cfg_en),
        .i_cfg_index     (cfg_idx),
        .i_cfg_wdata     (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hold-off before the next word, drawn at random, or none through a quiet run.
    function automatic int draw_gap(inout int left, inout bit quiet);
        if (left == 0) begin
            left  = $urandom_range(8, 40);
            quiet = ($urandom_range(0, 3) == 0);
        end
        left--;
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic lsi_pkg::t_sample pick_extreme();
        case ($urandom_range(0, 3))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'shffff;
        endcase
    endfunction

    // Random sample of about amp_bits bits of swing, with some full-scale hits.
    function automatic lsi_pkg::t_sample pick_sample(int amp_bits);
        lsi_pkg::t_sample raw;
        if ($urandom_range(0, 9) == 0) return pick_extreme();
        raw = lsi_pkg::t_sample'($urandom);
        return raw >>> (lsi_pkg::DATA_W - amp_bits);
    endfunction

    function automatic lsi_pkg::t_sample pick_step();
        case ($urandom_range(0, 3))
            0: return lsi_pkg::t_sample'($urandom_range(1, 200));
            1: return lsi_pkg::t_sample'($urandom);
            2: return pick_extreme();
            default: return lsi_pkg::t_sample'($urandom_range(200, 4096));
        endcase
    endfunction

    function automatic lsi_pkg::t_sample pick_coef();
        case ($urandom_range(0, 2))
            0: return lsi_pkg::t_sample'($urandom);
            1: return pick_extreme();
            default: return lsi_pkg::t_sample'($urandom_range(0, 32768)) - 16'sd16384;
        endcase
    endfunction

    // Push every word of batch through the slave side.
    task automatic stream_batch();
        int gap;
        foreach (batch[k]) begin
            gap = draw_gap(s_left, s_quiet);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_valid <= 1'b1;
            s_data  <= batch[k];
            do @(posedge clk); while (s_ready !== 1'b1);
            sb.note_sample(batch[k]);
        end
        s_valid <= 1'b0;
    endtask

    // All error words back, then let the trailing weight update finish.
    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves the enable high so back-to-back writes need no toggle; caller drops it.
    task automatic write_reg(logic [lsi_pkg::CFG_IDX_W-1:0] idx, lsi_pkg::t_sample val);
        cfg_en   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    // Master side: random stall before each word, then hold tready until it lands.
    initial begin
        int gap;
        forever begin
            gap = draw_gap(m_left, m_quiet);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_ready <= 1'b1;
            do @(posedge clk); while (m_valid !== 1'b1);
            if (rst_n) sb.check_error(m_data);
        end
    end

    // Watchdog: too long with no word moving on either side ends the run.
    always @(posedge clk) begin
        if ((s_valid && s_ready === 1'b1) || (m_ready && m_valid === 1'b1)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        int amp;
        sb = new(N_TAPS);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset coefficients, zero weights: full-scale steps, alternating bits,
        // tiny values where the floor shift of a negative product matters.
        batch = '{32767, 32767, -32768, -32768, 0, 1, -1, 21845, -21846, 100, -100};
        stream_batch();
        wait_drained();

        // Largest step, extreme coefficients; dropped writes to spare indexes.
        write_reg(lsi_pkg::REG_STEP, 16'sh7fff);
        write_reg(lsi_pkg::REG_COEF0, 16'sh8000);
        write_reg(lsi_pkg::REG_COEF0 + 3'd1, 16'sh7fff);
        write_reg(lsi_pkg::REG_COEF0 + 3'd2, 16'sh0000);
        write_reg(lsi_pkg::REG_COEF0 + 3'd3, 16'shffff);
        for (int k = 0; k < 3; k++) begin
            write_reg(REG_SPARE0 + lsi_pkg::CFG_IDX_W'(k), lsi_pkg::t_sample'($urandom));
        end
        cfg_en <= 1'b0;
        // sums and weights overflow and wrap here
        batch = '{-32768, 32767, -1, 1, 0, -32768, -32768, 32767};
        stream_batch();
        wait_drained();

        // Most negative step, all coefficients at full scale positive.
        write_reg(lsi_pkg::REG_STEP, 16'sh8000);
        for (int n = 0; n < N_TAPS; n++) begin
            write_reg(lsi_pkg::REG_COEF0 + lsi_pkg::CFG_IDX_W'(n), 16'sh7fff);
        end
        cfg_en <= 1'b0;
        batch = '{12345, -1, -32768, 32767, 3};
        stream_batch();
        wait_drained();

        // Random phases: new settings each time, amplitude chosen per phase so
        // small steps with small samples get to converge.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if ($urandom_range(0, 3) != 0) write_reg(lsi_pkg::REG_STEP, pick_step());
            for (int n = 0; n < N_TAPS; n++) begin
                if ($urandom_range(0, 3) != 0) begin
                    write_reg(lsi_pkg::REG_COEF0 + lsi_pkg::CFG_IDX_W'(n), pick_coef());
                end
            end
            if ($urandom_range(0, 1) == 0) begin
                write_reg(REG_SPARE0 + lsi_pkg::CFG_IDX_W'($urandom_range(0, 2)),
                          lsi_pkg::t_sample'($urandom));
            end
            cfg_en <= 1'b0;
            amp = (ph == 0) ? lsi_pkg::DATA_W : $urandom_range(4, lsi_pkg::DATA_W);
            batch.delete();
            repeat (PHASE_WORDS) batch.push_back(pick_sample(amp));
            stream_batch();
            wait_drained();
        end

        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
